// ===== hdl/sgfr_pkg.sv =====
// Shared types, constants and font table for the scaled glyph framebuffer renderer.
`timescale 1ns / 1ps

package sgfr_pkg;

  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int ADVANCE     = 6;
  localparam int GLYPH_COUNT = 37;
  localparam int SLOT_W      = 6;
  localparam int GCOL_W      = 3;

  localparam int REQ_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int POSX_W  = 7;
  localparam int POSY_W  = 6;
  localparam int SCALE_W = 3;
  localparam int IDX_W   = 10;
  localparam int CURC_W  = 8;
  localparam int RDATA_W = 8;

  typedef enum logic [1:0] {
    REQ_DRAW  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2
  } req_type_e;

  typedef enum logic [3:0] {
    ST_CLR_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLR_REQ,
    ST_MASK,
    ST_SHIFT,
    ST_PAGE_RD,
    ST_PAGE_WR,
    ST_ADVANCE,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic rd_issue;
    logic mask_load;
    logic vec_load;
    logic page_rd;
    logic page_wr;
    logic page_next;
    logic px_next;
    logic col_next;
    logic advance;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             skip;
    logic             vis;
    logic             clr_last;
    logic             page_last;
    logic             dx_last;
    logic             col_last;
  } dp_status_t;

  // 0 blank, 1..10 digits, 11..36 letters; each entry is one column, bit n = row n
  localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_COLS] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
    '{8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}
  };

  // ASCII to font slot; lower case folds to upper case, anything else is blank
  function automatic logic [SLOT_W-1:0] glyph_slot(input logic [CHAR_W-1:0] code);
    logic [SLOT_W-1:0] slot;
    slot = '0;
    if (code >= 8'h30 && code <= 8'h39) begin
      slot = SLOT_W'(code - 8'h30) + SLOT_W'(1);
    end else if (code >= 8'h41 && code <= 8'h5A) begin
      slot = SLOT_W'(code - 8'h41) + SLOT_W'(11);
    end else if (code >= 8'h61 && code <= 8'h7A) begin
      slot = SLOT_W'(code - 8'h61) + SLOT_W'(11);
    end
    return slot;
  endfunction

endpackage

// ===== hdl/sgfr_ctrl.sv =====
// Controller state machine: sequences clear sweeps, reads and glyph read-modify-write passes.
`timescale 1ns / 1ps

module sgfr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  sgfr_pkg::dp_status_t status_i,
  output sgfr_pkg::ctrl_cmd_t  cmd_o
);

  sgfr_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == sgfr_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sgfr_pkg::ST_CLR_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      sgfr_pkg::ST_CLR_INIT: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) state_d = sgfr_pkg::ST_IDLE;
      end
      sgfr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sgfr_pkg::ST_DECODE;
        end
      end
      sgfr_pkg::ST_DECODE: begin
        priority if (status_i.req == sgfr_pkg::REQ_DRAW) begin
          priority if (status_i.skip) state_d = sgfr_pkg::ST_DONE;
          else if (!status_i.vis)     state_d = sgfr_pkg::ST_ADVANCE;
          else                        state_d = sgfr_pkg::ST_MASK;
        end else if (status_i.req == sgfr_pkg::REQ_CLEAR) begin
          state_d = sgfr_pkg::ST_CLR_REQ;
        end else if (status_i.req == sgfr_pkg::REQ_READ) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = sgfr_pkg::ST_DONE;
        end else begin
          state_d = sgfr_pkg::ST_DONE;
        end
      end
      sgfr_pkg::ST_CLR_REQ: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) state_d = sgfr_pkg::ST_DONE;
      end
      sgfr_pkg::ST_MASK: begin
        cmd_o.mask_load = 1'b1;
        state_d         = sgfr_pkg::ST_SHIFT;
      end
      sgfr_pkg::ST_SHIFT: begin
        cmd_o.vec_load = 1'b1;
        state_d        = sgfr_pkg::ST_PAGE_RD;
      end
      sgfr_pkg::ST_PAGE_RD: begin
        cmd_o.page_rd = 1'b1;
        state_d       = sgfr_pkg::ST_PAGE_WR;
      end
      sgfr_pkg::ST_PAGE_WR: begin
        cmd_o.page_wr = 1'b1;
        priority if (!status_i.page_last) begin
          cmd_o.page_next = 1'b1;
          state_d         = sgfr_pkg::ST_PAGE_RD;
        end else if (!status_i.dx_last) begin
          cmd_o.px_next = 1'b1;
          state_d       = sgfr_pkg::ST_PAGE_RD;
        end else if (!status_i.col_last) begin
          cmd_o.px_next  = 1'b1;
          cmd_o.col_next = 1'b1;
          state_d        = sgfr_pkg::ST_MASK;
        end else begin
          state_d = sgfr_pkg::ST_ADVANCE;
        end
      end
      sgfr_pkg::ST_ADVANCE: begin
        cmd_o.advance = 1'b1;
        state_d       = sgfr_pkg::ST_DONE;
      end
      sgfr_pkg::ST_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = sgfr_pkg::ST_IDLE;
        end
      end
      default: state_d = sgfr_pkg::ST_IDLE;
    endcase
  end

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before transaction completed");

  a_rmw_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.page_wr |-> $past(cmd_o.page_rd))
    else $error("framebuffer write without preceding read");

  a_advance_draw_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.advance |-> (status_i.req == sgfr_pkg::REQ_DRAW && !status_i.skip))
    else $error("cursor advanced on a non-drawn request");

  a_result_follows_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("result not presented after load");

endmodule

// ===== hdl/sgfr_datapath.sv =====
// Datapath: request registers, cursor, glyph column masks and the framebuffer memory.
`timescale 1ns / 1ps

module sgfr_datapath #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int MAX_SCALE     = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sgfr_pkg::ctrl_cmd_t           cmd_i,
  output sgfr_pkg::dp_status_t          status_o,
  input  logic [sgfr_pkg::REQ_W-1:0]    req_type_i,
  input  logic [sgfr_pkg::CHAR_W-1:0]   char_code_i,
  input  logic                          first_char_i,
  input  logic [sgfr_pkg::POSX_W-1:0]   pos_x_i,
  input  logic [sgfr_pkg::POSY_W-1:0]   pos_y_i,
  input  logic [sgfr_pkg::SCALE_W-1:0]  scale_i,
  input  logic [sgfr_pkg::IDX_W-1:0]    byte_index_i,
  output logic [sgfr_pkg::RDATA_W-1:0]  read_data_o,
  output logic                          drawn_o
);

  localparam int FbPages = (SCREEN_HEIGHT + 7) / 8;
  localparam int FbBytes = SCREEN_WIDTH * FbPages;
  localparam int AddrW   = $clog2(FbBytes);
  localparam int PageW   = $clog2(FbPages);
  localparam int VecW    = FbPages * 8;
  localparam int MaskW   = sgfr_pkg::GLYPH_ROWS * MAX_SCALE;
  localparam int ShW     = VecW + MaskW;
  localparam int SclW    = $clog2(MAX_SCALE + 1);
  localparam int EndW    = $clog2(64 + MaskW + SCREEN_HEIGHT);

  logic [7:0] mem [FbBytes];

  logic [sgfr_pkg::REQ_W-1:0]  req_q;
  logic [sgfr_pkg::SLOT_W-1:0] slot_q;
  logic [SclW-1:0]             scl_q;
  logic [sgfr_pkg::IDX_W-1:0]  idx_q;
  logic                        skip_q, vis_q;
  logic [PageW-1:0]            first_page_q, last_page_q, page_q;
  logic [sgfr_pkg::CURC_W-1:0] cur_col_q, px_q;
  logic [sgfr_pkg::POSY_W-1:0] cur_row_q;
  logic [sgfr_pkg::GCOL_W-1:0] col_q;
  logic [SclW-1:0]             dx_q;
  logic [AddrW-1:0]            clr_cnt_q;
  logic [MaskW-1:0]            mask_q, mask_d;
  logic [VecW-1:0]             vec_q, vec_d, row_ok;
  logic [7:0]                  mem_rd_q;
  logic [sgfr_pkg::RDATA_W-1:0] read_data_q;
  logic                        drawn_q;

  // effective values at load
  logic [SclW-1:0]             scl_eff;
  logic [sgfr_pkg::CURC_W-1:0] x0_eff;
  logic [sgfr_pkg::POSY_W-1:0] y0_eff;
  logic [EndW-1:0]             end_row;
  logic                        ld_cursor;

  logic [AddrW-1:0]            pix_addr, rd_addr, wr_addr;
  logic [7:0]                  wr_data, glyph_col;
  logic                        mem_we, mem_re, clr_last;
  logic [MaskW-1:0]            ones;
  logic [ShW-1:0]              shifted;
  logic [8:0]                  next_col;

  always_comb begin
    if (scale_i == '0) begin
      scl_eff = SclW'(1);
    end else if (int'(scale_i) > MAX_SCALE) begin
      scl_eff = SclW'(MAX_SCALE);
    end else begin
      scl_eff = SclW'(scale_i);
    end
    ld_cursor = (req_type_i == sgfr_pkg::REQ_DRAW) && first_char_i;
    x0_eff    = first_char_i ? sgfr_pkg::CURC_W'(pos_x_i) : cur_col_q;
    y0_eff    = first_char_i ? pos_y_i : cur_row_q;
    end_row   = EndW'(y0_eff) + EndW'(sgfr_pkg::GLYPH_ROWS * int'(scl_eff)) - EndW'(1);
    if (int'(end_row) > SCREEN_HEIGHT - 1) end_row = EndW'(SCREEN_HEIGHT - 1);
  end

  assign glyph_col = sgfr_pkg::GLYPH_ROM[slot_q][col_q];

  // one glyph column stretched vertically by the scale
  always_comb begin
    ones   = (MaskW'(1) << scl_q) - MaskW'(1);
    mask_d = '0;
    for (int r = 0; r < sgfr_pkg::GLYPH_ROWS; r++) begin
      if (glyph_col[r]) mask_d = mask_d | (ones << (r * int'(scl_q)));
    end
  end

  always_comb begin
    for (int i = 0; i < VecW; i++) row_ok[i] = (i < SCREEN_HEIGHT);
    shifted = ShW'(mask_q) << cur_row_q;
    vec_d   = shifted[VecW-1:0] & row_ok;
  end

  assign clr_last = (int'(clr_cnt_q) == FbBytes - 1);
  assign pix_addr = AddrW'(int'(page_q) * SCREEN_WIDTH) + AddrW'(px_q);
  assign rd_addr  = cmd_i.rd_issue ? AddrW'(idx_q) : pix_addr;
  assign wr_addr  = cmd_i.clr_wr ? clr_cnt_q : pix_addr;
  assign wr_data  = cmd_i.clr_wr ? 8'h00 : (mem_rd_q | vec_q[{page_q, 3'b000} +: 8]);
  assign mem_we   = cmd_i.clr_wr || cmd_i.page_wr;
  assign mem_re   = cmd_i.rd_issue || cmd_i.page_rd;
  assign next_col = 9'(cur_col_q) + 9'(sgfr_pkg::ADVANCE * int'(scl_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (mem_re) mem_rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
      clr_cnt_q <= '0;
      req_q     <= '0;
      skip_q    <= 1'b0;
      vis_q     <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        req_q  <= req_type_i;
        skip_q <= (int'(x0_eff) + sgfr_pkg::GLYPH_COLS * int'(scl_eff)) >= SCREEN_WIDTH;
        vis_q  <= int'(y0_eff) < SCREEN_HEIGHT;
        if (ld_cursor) begin
          cur_col_q <= sgfr_pkg::CURC_W'(pos_x_i);
          cur_row_q <= pos_y_i;
        end
      end
      if (cmd_i.advance) begin
        cur_col_q <= (next_col > 9'd255) ? 8'hFF : next_col[7:0];
      end
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_last ? '0 : clr_cnt_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      slot_q       <= sgfr_pkg::glyph_slot(char_code_i);
      scl_q        <= scl_eff;
      idx_q        <= byte_index_i;
      first_page_q <= PageW'(y0_eff >> 3);
      last_page_q  <= PageW'(end_row >> 3);
      px_q         <= x0_eff;
      col_q        <= '0;
      dx_q         <= '0;
    end
    if (cmd_i.mask_load) mask_q <= mask_d;
    if (cmd_i.vec_load) begin
      vec_q  <= vec_d;
      page_q <= first_page_q;
    end
    if (cmd_i.page_next) page_q <= page_q + PageW'(1);
    if (cmd_i.px_next) begin
      px_q   <= px_q + 8'd1;
      page_q <= first_page_q;
      dx_q   <= cmd_i.col_next ? '0 : dx_q + SclW'(1);
    end
    if (cmd_i.col_next) col_q <= col_q + sgfr_pkg::GCOL_W'(1);
    if (cmd_i.out_load) begin
      read_data_q <= (req_q == sgfr_pkg::REQ_READ && int'(idx_q) < FbBytes) ? mem_rd_q : '0;
      drawn_q     <= (req_q == sgfr_pkg::REQ_DRAW) && !skip_q;
    end
  end

  assign status_o.req       = req_q;
  assign status_o.skip      = skip_q;
  assign status_o.vis       = vis_q;
  assign status_o.clr_last  = clr_last;
  assign status_o.page_last = (page_q == last_page_q);
  assign status_o.dx_last   = (dx_q == scl_q - SclW'(1));
  assign status_o.col_last  = (int'(col_q) == sgfr_pkg::GLYPH_COLS - 1);

  assign read_data_o = read_data_q;
  assign drawn_o     = drawn_q;

endmodule

// ===== hdl/scaled_glyph_framebuffer_renderer.sv =====
// Top level of the scaled glyph framebuffer renderer: stream ports, controller and datapath.
//
//  Port group   Dir  Transaction contents
//  s_axis_*     in   one request: draw character, clear framebuffer or read one byte
//  m_axis_*     out  one result per request: read byte and drawn flag
//
// Read: the byte is fetched in decode and returned via the done state. Clear: zeroes all
// pages*width bytes. Draw: each glyph column is written scale times over the pages that
// the scaled glyph covers; each touched byte is a read-modify-write on the single framebuffer port.
// After reset a clearing pass over all pages*width bytes (1024 by default) runs with
// s_axis_tready low. One request is in flight at a time; a finished result waits
// in the output register while the next request is accepted.
`timescale 1ns / 1ps

module scaled_glyph_framebuffer_renderer #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int MAX_SCALE     = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // char_code[7:0], first_char[8], pos_x[15:9], pos_y[21:16], scale[24:22],
  // byte_index[34:25], zero pad[39:35]
  input  logic [39:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0], drawn[8], zero pad[15:9]
  output logic [15:0] m_axis_tdata
);

  sgfr_pkg::ctrl_cmd_t  cmd;
  sgfr_pkg::dp_status_t status;
  logic [sgfr_pkg::RDATA_W-1:0] read_data;
  logic                         drawn;

  sgfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sgfr_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .MAX_SCALE     (MAX_SCALE)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .req_type_i   (s_axis_tuser),
    .char_code_i  (s_axis_tdata[7:0]),
    .first_char_i (s_axis_tdata[8]),
    .pos_x_i      (s_axis_tdata[15:9]),
    .pos_y_i      (s_axis_tdata[21:16]),
    .scale_i      (s_axis_tdata[24:22]),
    .byte_index_i (s_axis_tdata[34:25]),
    .read_data_o  (read_data),
    .drawn_o      (drawn)
  );

  assign m_axis_tdata = {7'd0, drawn, read_data};

endmodule
